FILE: src/mfb_pkg.sv
`default_nettype none

package mfb_pkg;

	// Default screen geometry in pixels.
	localparam int SCREEN_WIDTH_DEF  = 800;
	localparam int SCREEN_HEIGHT_DEF = 480;

	// Coordinate widths that hold any on-screen position for the largest supported screen.
	localparam int PIX_W  = 12;
	localparam int ROW_W  = 12;
	localparam int BCOL_W = PIX_W - 3;

	// Depth of the command queue between the front and back parts.
	localparam int CMDQ_DEPTH = 4;

	// Byte patterns for a white byte and for a byte with no bits selected.
	localparam logic [7:0] BYTE_WHITE = 8'hFF;
	localparam logic [7:0] BYTE_NONE  = 8'h00;

	// Command codes.
	localparam logic OP_FILL = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Input word as it arrives from the host.
	typedef struct packed {
		logic               op;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
		logic               color_black;
		logic [15:0]        read_addr;
	} in_word_t;

	// Result word returned for every command.
	typedef struct packed {
		logic       was_read;
		logic [7:0] read_data;
	} out_word_t;

	// Classified command, with the rectangle already clipped to the screen.
	typedef struct packed {
		logic              is_read;
		logic              black;
		logic              none;
		logic [ROW_W-1:0]  row_first;
		logic [ROW_W-1:0]  row_last;
		logic [BCOL_W-1:0] bcol_first;
		logic [BCOL_W-1:0] bcol_last;
		logic [7:0]        lmask;
		logic [7:0]        rmask;
		logic [15:0]       raddr;
		logic              raddr_ok;
	} cmd_t;

endpackage

`default_nettype wire

FILE: src/mfb_front.sv
`default_nettype none

module mfb_front
	import mfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire in_word_t push_word,
	input  wire logic     push,
	output logic          full,
	input  wire logic     busy,
	input  wire logic     q_full,
	output logic          q_push,
	output cmd_t          q_cmd
);

	localparam int STRIDE   = (SCREEN_WIDTH + 7) / 8;
	localparam int FB_BYTES = STRIDE * SCREEN_HEIGHT;
	localparam logic signed [17:0] W18 = 18'(SCREEN_WIDTH);
	localparam logic signed [17:0] H18 = 18'(SCREEN_HEIGHT);

	logic signed [17:0] xs, ys, ws, hs, xe, ye;
	logic signed [17:0] x0, y0, x1, y1, xl, yl;
	logic               none_x, none_y;

	// Words are refused while the queue is full or the store is being cleared.
	assign full   = q_full | busy;
	assign q_push = push & ~full;

	// Sign-extend the edges so that the far-edge sums cannot overflow.
	assign xs = {{2{push_word.rect_x[15]}}, push_word.rect_x};
	assign ys = {{2{push_word.rect_y[15]}}, push_word.rect_y};
	assign ws = {{2{push_word.rect_width[15]}}, push_word.rect_width};
	assign hs = {{2{push_word.rect_height[15]}}, push_word.rect_height};
	assign xe = xs + ws;
	assign ye = ys + hs;

	// Clip to the screen; the far edges are exclusive.
	assign x0 = xs[17] ? '0 : xs;
	assign y0 = ys[17] ? '0 : ys;
	assign x1 = (xe > W18) ? W18 : xe;
	assign y1 = (ye > H18) ? H18 : ye;
	assign xl = x1 - 18'sd1;
	assign yl = y1 - 18'sd1;
	assign none_x = (x1 <= x0);
	assign none_y = (y1 <= y0);

	// Byte span and edge masks of the clipped rectangle.
	always_comb begin
		q_cmd            = '0;
		q_cmd.is_read    = (push_word.op == OP_READ);
		q_cmd.black      = push_word.color_black;
		q_cmd.none       = none_x | none_y;
		q_cmd.row_first  = y0[ROW_W-1:0];
		q_cmd.row_last   = yl[ROW_W-1:0];
		q_cmd.bcol_first = x0[PIX_W-1:3];
		q_cmd.bcol_last  = xl[PIX_W-1:3];
		q_cmd.lmask      = BYTE_WHITE >> x0[2:0];
		q_cmd.rmask      = BYTE_WHITE << (3'd7 - xl[2:0]);
		q_cmd.raddr      = push_word.read_addr;
		q_cmd.raddr_ok   = ({16'd0, push_word.read_addr} < 32'(FB_BYTES));
	end

endmodule

`default_nettype wire

FILE: src/mfb_cmd_queue.sv
`default_nettype none

module mfb_cmd_queue
	import mfb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output cmd_t      rd_cmd
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          entries_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_cmd  = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/mfb_back.sv
`default_nettype none

module mfb_back
	import mfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_empty,
	input  wire cmd_t      q_cmd,
	output logic           q_pop,
	output logic           clearing,
	output logic           res_empty,
	input  wire logic      res_pop,
	output out_word_t      res_word
);

	localparam int STRIDE   = (SCREEN_WIDTH + 7) / 8;
	localparam int FB_BYTES = STRIDE * SCREEN_HEIGHT;
	localparam int AW       = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_FILL  = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	logic [7:0]        pixel_store_q [FB_BYTES];
	logic [7:0]        rdata_q;
	logic [1:0]        state_q;
	logic [AW-1:0]     clr_addr_q, row_base_q;
	logic [ROW_W-1:0]  row_q, row_last_q;
	logic [BCOL_W-1:0] bcol_q, bcol_first_q, bcol_last_q;
	logic [7:0]        lmask_q, rmask_q;
	logic              black_q, rd_ok_q;
	logic              wr_pend_s2, black_s2;
	logic [AW-1:0]     addr_s2;
	logic [7:0]        mask_s2;
	logic              out_valid_q;
	out_word_t         out_q;

	logic              start, last_col, last_row;
	logic [AW-1:0]     fill_addr, mem_raddr, mem_waddr;
	logic [7:0]        col_mask, mem_wdata;
	logic              mem_re, mem_we;

	// A new command starts only when no write is outstanding and the result slot is free.
	assign start     = (state_q == ST_IDLE) && !q_empty && !wr_pend_s2 && !out_valid_q;
	assign q_pop     = start;
	assign clearing  = (state_q == ST_CLEAR);
	assign res_empty = ~out_valid_q;
	assign res_word  = out_q;

	// Current byte of the fill sweep and its bit mask.
	assign fill_addr = row_base_q + AW'(bcol_q);
	assign last_col  = (bcol_q == bcol_last_q);
	assign last_row  = (row_q == row_last_q);
	assign col_mask  = ((bcol_q == bcol_first_q) ? lmask_q : BYTE_WHITE) &
		(last_col ? rmask_q : BYTE_WHITE);

	// Read port: the fill sweep or a host read.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = fill_addr;
		priority if (state_q == ST_FILL) begin
			mem_re = 1'b1;
		end else if (start && q_cmd.is_read && q_cmd.raddr_ok) begin
			mem_re    = 1'b1;
			mem_raddr = AW'(q_cmd.raddr);
		end
	end

	// Write port: the clearing pass or the second half of a read-modify-write.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s2;
		mem_wdata = black_s2 ? (rdata_q & ~mask_s2) : (rdata_q | mask_s2);
		priority if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = BYTE_WHITE;
		end else if (wr_pend_s2) begin
			mem_we = 1'b1;
		end
	end

	// Pixel store with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pixel_store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= pixel_store_q[mem_raddr];
		end
	end

	// Sequencer and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			wr_pend_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_pend_s2 <= (state_q == ST_FILL);
			if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == AW'(FB_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (q_cmd.is_read) begin
							state_q <= ST_READ;
						end else if (q_cmd.none) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					if (last_col && last_row) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sweep position, pipeline payload and result word.
	always_ff @(posedge clk) begin
		addr_s2  <= fill_addr;
		mask_s2  <= col_mask;
		black_s2 <= black_q;
		if (start) begin
			row_q        <= q_cmd.row_first;
			row_last_q   <= q_cmd.row_last;
			bcol_q       <= q_cmd.bcol_first;
			bcol_first_q <= q_cmd.bcol_first;
			bcol_last_q  <= q_cmd.bcol_last;
			lmask_q      <= q_cmd.lmask;
			rmask_q      <= q_cmd.rmask;
			black_q      <= q_cmd.black;
			rd_ok_q      <= q_cmd.raddr_ok;
			row_base_q   <= AW'(q_cmd.row_first) * AW'(STRIDE);
		end else if (state_q == ST_FILL) begin
			if (last_col) begin
				bcol_q     <= bcol_first_q;
				row_q      <= row_q + 1'b1;
				row_base_q <= row_base_q + AW'(STRIDE);
			end else begin
				bcol_q <= bcol_q + 1'b1;
			end
		end
		if (state_q == ST_READ) begin
			out_q.was_read  <= 1'b1;
			out_q.read_data <= rd_ok_q ? rdata_q : BYTE_NONE;
		end else if (!out_valid_q) begin
			out_q.was_read  <= 1'b0;
			out_q.read_data <= BYTE_NONE;
		end
	end

	// The command queue is only drained when the sequencer is idle.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE))
		else $error("command taken while the sequencer was busy");

	// Every store write lands inside the framebuffer.
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(FB_BYTES)))
		else $error("store write beyond the framebuffer");

	// A host read never overlaps the tail write of a fill.
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !wr_pend_s2)
		else $error("read issued while a fill write was pending");

	// A waiting result is never overwritten by a finishing command.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_pop) |=> out_valid_q && $stable(out_q))
		else $error("waiting result word was disturbed");

	// No fill write is in flight during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !wr_pend_s2 && !out_valid_q)
		else $error("activity during the clearing pass");

endmodule

`default_nettype wire

FILE: src/mono_framebuffer_rect_fill_unit.sv
// Read word: the result passes through the queue, the store read and the result register.
// Fill word: the sweep covers byte span times row count bytes, one per cycle, set by the
// single read-modify-write port of the store; an empty rectangle completes with no sweep.
// Up to four words queue in front of the back part, which takes one word at a time.
// Reset: asynchronous, active low; a clearing pass then writes white to every byte, one per
// cycle, stride times SCREEN_HEIGHT bytes (48000 by default), with full held high.
`default_nettype none

module mono_framebuffer_rect_fill_unit
	import mfb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t cmd,
	output logic          empty,
	input  wire logic     pop,
	output out_word_t     result
);

	logic q_full, q_push, q_empty, q_pop, clearing;
	cmd_t q_wr_cmd, q_rd_cmd;

	// Front part: accepts and classifies each word.
	mfb_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.push_word(cmd),
		.push     (push),
		.full     (full),
		.busy     (clearing),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_wr_cmd)
	);

	// Queue between the two parts.
	mfb_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wr_cmd(q_wr_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.empty (q_empty),
		.rd_cmd(q_rd_cmd)
	);

	// Back part: owns the store and returns one result word per command.
	mfb_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cmd    (q_rd_cmd),
		.q_pop    (q_pop),
		.clearing (clearing),
		.res_empty(empty),
		.res_pop  (pop),
		.res_word (result)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import mfb_pkg::*;

	localparam int SCREEN_W  = SCREEN_WIDTH_DEF;
	localparam int SCREEN_H  = SCREEN_HEIGHT_DEF;
	localparam int FB_STRIDE = (SCREEN_W + 7) / 8;
	localparam int FB_BYTES  = FB_STRIDE * SCREEN_H;

	logic      clk    = 1'b1;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_word_t  cmd    = '0;
	logic      full;
	logic      empty;
	out_word_t result;

	// Words still to be sent, replies still due, and our own copy of the screen.
	in_word_t  cmd_backlog[$];
	out_word_t due_replies[$];
	logic [7:0] frame_copy [0:FB_BYTES-1];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  fail_count     = 0;
	bit  word_taken     = 1'b0;

	mono_framebuffer_rect_fill_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b0;
		#2 clk = 1'b1;
	end

	// Applies one command to the screen copy and returns the reply it should produce.
	function automatic out_word_t apply_to_frame_copy(input in_word_t c);
		out_word_t r;
		int x0, y0, x1, y1, idx;
		logic [7:0] mask;
		r = '0;
		if (c.op == OP_READ) begin
			r.was_read = 1'b1;
			if (c.read_addr < FB_BYTES)
				r.read_data = frame_copy[c.read_addr];
		end else begin
			// Edges are summed in 32 bits, so nothing overflows before clipping.
			x0 = $signed(c.rect_x);
			y0 = $signed(c.rect_y);
			x1 = x0 + int'($signed(c.rect_width));
			y1 = y0 + int'($signed(c.rect_height));
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > SCREEN_W) x1 = SCREEN_W;
			if (y1 > SCREEN_H) y1 = SCREEN_H;
			for (int row = y0; row < y1; row++) begin
				for (int col = x0; col < x1; col++) begin
					idx  = row * FB_STRIDE + (col >> 3);
					mask = 8'h80 >> (col & 7);
					if (c.color_black)
						frame_copy[idx] = frame_copy[idx] & ~mask;
					else
						frame_copy[idx] = frame_copy[idx] | mask;
				end
			end
		end
		return r;
	endfunction

	// A fill word; the unused read address carries random bits.
	function automatic in_word_t make_fill(input int x, input int y, input int w, input int h,
			input bit black);
		in_word_t c;
		c.op          = OP_FILL;
		c.rect_x      = x[15:0];
		c.rect_y      = y[15:0];
		c.rect_width  = w[15:0];
		c.rect_height = h[15:0];
		c.color_black = black;
		c.read_addr   = 16'($urandom_range(65535));
		return c;
	endfunction

	// A read word; the unused rectangle and colour fields carry random bits.
	function automatic in_word_t make_read(input int addr);
		in_word_t c;
		c.op          = OP_READ;
		c.rect_x      = 16'($urandom_range(65535));
		c.rect_y      = 16'($urandom_range(65535));
		c.rect_width  = 16'($urandom_range(65535));
		c.rect_height = 16'($urandom_range(65535));
		c.color_black = 1'($urandom_range(1));
		c.read_addr   = addr[15:0];
		return c;
	endfunction

	// Random mix of reads and fills, mostly small rectangles around the screen.
	task automatic queue_random_words(input int count);
		int x, y, w, h, pick, addr;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(999);
			if (pick < 350) begin
				if ($urandom_range(9) == 0)
					addr = $urandom_range(65535);
				else
					addr = $urandom_range(FB_BYTES - 1);
				cmd_backlog.push_back(make_read(addr));
			end else begin
				if (pick < 355) begin
					// Screen-sized fill, kept rare because it costs a byte per cycle.
					x = $urandom_range(300);
					y = $urandom_range(300);
					x = -x;
					y = -y;
					w = 800 + $urandom_range(1500);
					h = 480 + $urandom_range(1500);
				end else if (pick < 455) begin
					// Full-range fields; a rectangle both wide and tall is cut down in height.
					x = $urandom_range(65535);
					y = $urandom_range(65535);
					w = $urandom_range(65535);
					h = $urandom_range(65535);
					x = x - 32768;
					y = y - 32768;
					w = w - 32768;
					h = h - 32768;
					if (w > 64 && h > 64)
						h = h % 32;
				end else begin
					x = $urandom_range(SCREEN_W + 31);
					y = $urandom_range(SCREEN_H + 15);
					w = $urandom_range(52);
					h = $urandom_range(28);
					x = x - 16;
					y = y - 8;
					w = w - 4;
					h = h - 4;
				end
				cmd_backlog.push_back(make_fill(x, y, w, h, 1'($urandom_range(1))));
			end
		end
	endtask

	// Sets the idling of both sides, then holds until every queued word has its reply.
	task automatic run_phase(input int send_idle, input int recv_stall);
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		while (cmd_backlog.size() != 0 || due_replies.size() != 0)
			@(posedge clk);
	endtask

	// Acceptance of a command word: predict its reply and drop it from the backlog.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			due_replies.push_back(apply_to_frame_copy(cmd));
			cmd_backlog.delete(0);
			word_taken = 1'b1;
		end
	end

	// Sender: a word is held until taken, then the next one is offered or the line idles.
	always @(negedge clk) begin
		if (!push || word_taken) begin
			word_taken = 1'b0;
			if (arst_n && cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd  <= cmd_backlog[0];
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Each reply word taken is checked against the oldest one due.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (due_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none, got was_read=%0b read_data=%02h",
					$time, result.was_read, result.read_data);
				fail_count++;
			end else begin
				want = due_replies.pop_front();
				if (result.was_read !== want.was_read || result.read_data !== want.read_data) begin
					$display("%0t: reply mismatch, expected was_read=%0b read_data=%02h, got was_read=%0b read_data=%02h",
						$time, want.was_read, want.read_data, result.was_read, result.read_data);
					fail_count++;
				end
			end
		end
	end

	// Watchdog for a hung block.
	initial begin
		#40_000_000;
		$display("mono_framebuffer_rect_fill_unit regression: fail");
		$finish;
	end

	initial begin
		// The screen comes out of reset all white.
		for (int i = 0; i < FB_BYTES; i++)
			frame_copy[i] = 8'hFF;
		// Reset is held low, then released on a falling clock edge.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words: address extremes, edge pixels, clipping and empty rectangles.
		cmd_backlog.push_back(make_read(0));
		cmd_backlog.push_back(make_read(FB_BYTES - 1));
		cmd_backlog.push_back(make_read(FB_BYTES));
		cmd_backlog.push_back(make_read(65535));
		cmd_backlog.push_back(make_fill(0, 0, 1, 1, 1'b1));
		cmd_backlog.push_back(make_read(0));
		cmd_backlog.push_back(make_fill(SCREEN_W - 1, SCREEN_H - 1, 1, 1, 1'b1));
		cmd_backlog.push_back(make_read(FB_BYTES - 1));
		cmd_backlog.push_back(make_fill(0, 0, 1, 1, 1'b0));
		cmd_backlog.push_back(make_fill(-100, -100, 50, 50, 1'b1));
		cmd_backlog.push_back(make_fill(10, 10, 0, 10, 1'b1));
		cmd_backlog.push_back(make_fill(10, 10, 10, -5, 1'b1));
		cmd_backlog.push_back(make_fill(SCREEN_W, 0, 10, 10, 1'b1));
		cmd_backlog.push_back(make_fill(-5, -3, 20, 6, 1'b1));
		cmd_backlog.push_back(make_read(0));
		cmd_backlog.push_back(make_read(FB_STRIDE * 2 + 1));
		cmd_backlog.push_back(make_fill(SCREEN_W - 10, SCREEN_H - 5, 100, 100, 1'b1));
		cmd_backlog.push_back(make_read(FB_STRIDE * (SCREEN_H - 1) + FB_STRIDE - 2));
		cmd_backlog.push_back(make_fill(32767, 32767, 32767, 32767, 1'b1));
		cmd_backlog.push_back(make_fill(-32768, -32768, 32767, -32768, 1'b1));
		cmd_backlog.push_back(make_fill(0, 0, SCREEN_W, SCREEN_H, 1'b1));
		cmd_backlog.push_back(make_read(12345));
		cmd_backlog.push_back(make_fill(-1000, -1000, 32767, 32767, 1'b0));
		cmd_backlog.push_back(make_read(FB_BYTES / 2));
		run_phase(0, 0);

		// Random words under each idling pattern; each phase drains before the next.
		queue_random_words(200);
		run_phase(0, 0);
		queue_random_words(200);
		run_phase(87, 0);
		queue_random_words(200);
		run_phase(0, 87);
		queue_random_words(200);
		run_phase(28, 28);

		repeat (20) @(posedge clk);
		if (fail_count == 0 && due_replies.size() == 0) begin
			$display("mono_framebuffer_rect_fill_unit regression: pass");
		end else begin
			$display("mono_framebuffer_rect_fill_unit regression: fail");
		end
		$finish;
	end

endmodule
